FILE: hw/rtl/ier_pkg.sv
// Package for the input event remapper: sizes, entry layout, state and code names.
// Used by ier_ram users and by input_event_remapper_core; depends on nothing.
package ier_pkg;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W       = $clog2(ENTRIES + 1);
  localparam int unsigned MAX_RESULTS = 20;
  localparam int unsigned NRES_W      = 5;
  localparam logic [15:0] LOW_MASK    = 16'hffff;

  // Result kinds.
  localparam logic [1:0] KIND_BUTTON  = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_INS_OK  = 2'd2;
  localparam logic [1:0] KIND_INS_FUL = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HAT   = 3'd0;
  localparam logic [2:0] CFG_LEFT  = 3'd1;
  localparam logic [2:0] CFG_RIGHT = 3'd2;
  localparam logic [2:0] CFG_UP    = 3'd3;
  localparam logic [2:0] CFG_DOWN  = 3'd4;

  // One table entry as held in the entry memory.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] low;
    logic [31:0] high;
    logic [17:0] dest;
    logic [31:0] prev;
    logic        pout;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EV_READ,
    S_EV_EVAL,
    S_EV_EMIT,
    S_INS_READ,
    S_INS_EVAL,
    S_INS_PUT,
    S_RESP
  } state_e;

  // Hat direction (x in [1:0], y in [3:2], each -1, 0 or +1) for an offset value.
  function automatic logic [3:0] hat_dir(input logic [31:0] d);
    logic [3:0] r;
    r = 4'b0000;
    if (d[31:3] == '0) begin
      case (d[2:0])
        3'd0:    r = {2'b11, 2'b00};
        3'd1:    r = {2'b11, 2'b01};
        3'd2:    r = {2'b00, 2'b01};
        3'd3:    r = {2'b01, 2'b01};
        3'd4:    r = {2'b01, 2'b00};
        3'd5:    r = {2'b01, 2'b11};
        3'd6:    r = {2'b00, 2'b11};
        3'd7:    r = {2'b11, 2'b11};
        default: r = 4'b0000;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/ier_ram.sv
// Generic single-write, single-read memory with registered read data.
// Stand-alone; no package needed.
module ier_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/input_event_remapper_core.sv
// Input event remapper: an event reads and evaluates each table entry in turn, reporting
// its queued button changes; an insert walks down from the top, moving entries up, then
// writes the new one; a rejected insert or an event on an empty table goes straight to
// its closing result. Receiver stalls hold the item. Uses ier_pkg and ier_ram.
// One item at a time; the next is taken the cycle after its closing result is registered.
// Reset clears count, bitmaps, output valid and pending changes, not the memory.
module input_event_remapper_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: source_id, event_value, range_low, range_high, dest_id, zero fill
  input  logic [151:0] s_axis_tdata,
  // tuser: opcode
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: button_id, button_value, button_bitmap, mapped_buttons, zero fill
  output logic [55:0]  m_axis_tdata,
  // tuser: kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [17:0]  cfg_data_i
);

  ier_pkg::state_e state_q, state_d;

  logic [17:0] hat_code_q;
  logic [15:0] left_q, right_q, up_q, down_q;

  logic [ier_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ier_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [ier_pkg::NRES_W-1:0] nres_q, nres_d;
  logic [15:0] bitmap_q, bitmap_d;
  logic [15:0] mapped_q, mapped_d;
  logic [1:0]  resp_kind_q, resp_kind_d;

  // Latched input item.
  logic [31:0] src_q, val_q, lo_q, hi_q;
  logic [17:0] dst_q;

  // Pending button changes of the current entry.
  logic [3:0]  pend_q, pend_d;
  logic [17:0] pend_id_q [4];
  logic [17:0] pend_id_d [4];
  logic [3:0]  pend_val_q, pend_val_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_kind_q, out_kind_d;
  logic [17:0] out_id_q, out_id_d;
  logic        out_bval_q, out_bval_d;
  logic        out_last_q, out_last_d;
  logic [15:0] out_bmp_q, out_bmp_d;
  logic [15:0] out_map_q, out_map_d;

  // Memory port.
  logic                       ram_we;
  logic [ier_pkg::IDX_W-1:0]  ram_waddr, ram_raddr;
  ier_pkg::entry_t            ram_wdata, ram_rdata;

  logic slot_free;
  logic in_fire;
  logic last_idx;

  // Evaluation helpers.
  logic [3:0]  dir_old, dir_new;
  logic        in_range;
  logic [1:0]  sel;
  logic [17:0] sel_id;
  logic        sel_val;
  logic [15:0] bmp_upd;

  ier_ram #(
    .WIDTH(ier_pkg::ENTRY_W),
    .DEPTH(ier_pkg::ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ier_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign last_idx      = (ier_pkg::CNT_W'({1'b0, idx_q}) + ier_pkg::CNT_W'(1)) == count_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_map_q, out_bmp_q, out_bval_q, out_id_q};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hat_code_q <= 18'd65536;
      left_q     <= 16'd1;
      right_q    <= 16'd2;
      up_q       <= 16'd4;
      down_q     <= 16'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ier_pkg::CFG_HAT:   hat_code_q <= cfg_data_i;
        ier_pkg::CFG_LEFT:  left_q     <= cfg_data_i[15:0];
        ier_pkg::CFG_RIGHT: right_q    <= cfg_data_i[15:0];
        ier_pkg::CFG_UP:    up_q       <= cfg_data_i[15:0];
        ier_pkg::CFG_DOWN:  down_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Input item latch.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      src_q <= s_axis_tdata[31:0];
      val_q <= s_axis_tdata[63:32];
      lo_q  <= s_axis_tdata[95:64];
      hi_q  <= s_axis_tdata[127:96];
      dst_q <= s_axis_tdata[145:128];
    end
  end

  // Entry evaluation: hat directions, range test and the first pending change.
  always_comb begin
    dir_old  = ier_pkg::hat_dir(ram_rdata.prev - ram_rdata.low);
    dir_new  = ier_pkg::hat_dir(val_q - ram_rdata.low);
    in_range = ($signed(val_q) >= $signed(ram_rdata.low)) &&
               ($signed(val_q) <= $signed(ram_rdata.high));
    sel = 2'd3;
    for (int k = 3; k >= 0; k--) begin
      if (pend_q[k]) begin
        sel = 2'(k);
      end
    end
    sel_id  = pend_id_q[sel];
    sel_val = pend_val_q[sel];
    bmp_upd = bitmap_q;
    if (sel_id[17:16] == 2'b00) begin
      bmp_upd = sel_val ? (bitmap_q | sel_id[15:0]) : (bitmap_q & ~sel_id[15:0]);
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    nres_d      = nres_q;
    bitmap_d    = bitmap_q;
    mapped_d    = mapped_q;
    resp_kind_d = resp_kind_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    pend_val_d  = pend_val_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_raddr   = idx_q;
    ram_wdata   = ram_rdata;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_id_d    = out_id_q;
    out_bval_d  = out_bval_q;
    out_last_d  = out_last_q;
    out_bmp_d   = out_bmp_q;
    out_map_d   = out_map_q;

    case (state_q)
      ier_pkg::S_IDLE: begin
        if (in_fire) begin
          nres_d = '0;
          if (s_axis_tuser[0]) begin
            if (count_q == ier_pkg::CNT_W'(ier_pkg::ENTRIES)) begin
              resp_kind_d = ier_pkg::KIND_INS_FUL;
              state_d     = ier_pkg::S_RESP;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = ier_pkg::S_INS_PUT;
            end else begin
              idx_d   = ier_pkg::IDX_W'(count_q - ier_pkg::CNT_W'(1));
              state_d = ier_pkg::S_INS_READ;
            end
          end else begin
            idx_d = '0;
            if (count_q == '0) begin
              resp_kind_d = ier_pkg::KIND_DONE;
              state_d     = ier_pkg::S_RESP;
            end else begin
              state_d = ier_pkg::S_EV_READ;
            end
          end
        end
      end

      ier_pkg::S_EV_READ: begin
        ram_raddr = idx_q;
        state_d   = ier_pkg::S_EV_EVAL;
      end

      // Compare the entry, write it back if its value changed, queue changes.
      ier_pkg::S_EV_EVAL: begin
        pend_d = 4'b0000;
        if (ram_rdata.src == src_q && ram_rdata.prev != val_q) begin
          ram_we         = 1'b1;
          ram_waddr      = idx_q;
          ram_wdata.prev = val_q;
          if (ram_rdata.dest == hat_code_q) begin
            if (dir_old[1:0] != dir_new[1:0]) begin
              pend_d[0]     = dir_old[1:0] != 2'b00;
              pend_id_d[0]  = {2'b00, dir_old[1] ? left_q : right_q};
              pend_val_d[0] = 1'b0;
              pend_d[1]     = dir_new[1:0] != 2'b00;
              pend_id_d[1]  = {2'b00, dir_new[1] ? left_q : right_q};
              pend_val_d[1] = 1'b1;
            end
            if (dir_old[3:2] != dir_new[3:2]) begin
              pend_d[2]     = dir_old[3:2] != 2'b00;
              pend_id_d[2]  = {2'b00, dir_old[3] ? up_q : down_q};
              pend_val_d[2] = 1'b0;
              pend_d[3]     = dir_new[3:2] != 2'b00;
              pend_id_d[3]  = {2'b00, dir_new[3] ? up_q : down_q};
              pend_val_d[3] = 1'b1;
            end
          end else if (in_range != ram_rdata.pout) begin
            ram_wdata.pout = in_range;
            pend_d[0]      = 1'b1;
            pend_id_d[0]   = ram_rdata.dest;
            pend_val_d[0]  = in_range;
          end
        end
        state_d = ier_pkg::S_EV_EMIT;
      end

      // Report queued changes one a cycle when the output is free; then the next entry.
      ier_pkg::S_EV_EMIT: begin
        if (pend_q != 4'b0000) begin
          if (nres_q < ier_pkg::NRES_W'(ier_pkg::MAX_RESULTS - 1)) begin
            if (slot_free) begin
              bitmap_d    = bmp_upd;
              pend_d[sel] = 1'b0;
              nres_d      = nres_q + ier_pkg::NRES_W'(1);
              out_valid_d = 1'b1;
              out_kind_d  = ier_pkg::KIND_BUTTON;
              out_id_d    = sel_id;
              out_bval_d  = sel_val;
              out_last_d  = 1'b0;
              out_bmp_d   = bmp_upd;
              out_map_d   = mapped_q;
            end
          end else begin
            bitmap_d    = bmp_upd;
            pend_d[sel] = 1'b0;
          end
        end else if (last_idx) begin
          resp_kind_d = ier_pkg::KIND_DONE;
          state_d     = ier_pkg::S_RESP;
        end else begin
          idx_d   = idx_q + ier_pkg::IDX_W'(1);
          state_d = ier_pkg::S_EV_READ;
        end
      end

      ier_pkg::S_INS_READ: begin
        ram_raddr = idx_q;
        state_d   = ier_pkg::S_INS_EVAL;
      end

      // Walk down from the top, moving entries with a source not below the new one.
      ier_pkg::S_INS_EVAL: begin
        if (ram_rdata.src >= src_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q + ier_pkg::IDX_W'(1);
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = ier_pkg::S_INS_PUT;
          end else begin
            idx_d   = idx_q - ier_pkg::IDX_W'(1);
            state_d = ier_pkg::S_INS_READ;
          end
        end else begin
          idx_d   = idx_q + ier_pkg::IDX_W'(1);
          state_d = ier_pkg::S_INS_PUT;
        end
      end

      ier_pkg::S_INS_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = idx_q;
        ram_wdata.src  = src_q;
        ram_wdata.low  = lo_q;
        ram_wdata.high = hi_q;
        ram_wdata.dest = dst_q;
        ram_wdata.prev = '0;
        ram_wdata.pout = 1'b0;
        count_d        = count_q + ier_pkg::CNT_W'(1);
        if (dst_q[17:16] == 2'b00) begin
          mapped_d = mapped_q | dst_q[15:0];
        end
        resp_kind_d = ier_pkg::KIND_INS_OK;
        state_d     = ier_pkg::S_RESP;
      end

      // Closing result of the item.
      ier_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = resp_kind_q;
          out_id_d    = '0;
          out_bval_d  = 1'b0;
          out_last_d  = 1'b1;
          out_bmp_d   = bitmap_q;
          out_map_d   = mapped_q;
          state_d     = ier_pkg::S_IDLE;
        end
      end

      default: state_d = ier_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ier_pkg::S_IDLE;
      count_q     <= '0;
      bitmap_q    <= '0;
      mapped_q    <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bitmap_q    <= bitmap_d;
      mapped_q    <= mapped_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    nres_q      <= nres_d;
    resp_kind_q <= resp_kind_d;
    pend_id_q   <= pend_id_d;
    pend_val_q  <= pend_val_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_bval_q  <= out_bval_d;
    out_last_q  <= out_last_d;
    out_bmp_q   <= out_bmp_d;
    out_map_q   <= out_map_d;
  end

endmodule
